### src/lrbm_pkg.sv
// Shared types and constants for the longest-run merge unit.
// Used by every module of the block but lrbm_ram; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package lrbm_pkg;

	// Table range and field widths
	localparam int VALUE_BITS  = 10;
	localparam int IN_VALUE_W  = 10;
	localparam int OUT_LEN_W   = 11;
	localparam int LEN_W       = VALUE_BITS + 1;
	localparam int TABLE_DEPTH = 1 << VALUE_BITS;
	localparam int EPOCH_W     = 8;

	localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;
	localparam logic [EPOCH_W-1:0]    EPOCH_MAX = '1;
	localparam logic [EPOCH_W-1:0]    EPOCH_SWEPT = '0;
	localparam logic [EPOCH_W-1:0]    EPOCH_FIRST = EPOCH_W'(1);

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	// One table entry: the entry is present when its tag matches the live epoch
	typedef struct packed {
		logic [EPOCH_W-1:0] tag;
		logic [LEN_W-1:0]   len;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Result handed from the controller to the output register
	typedef struct packed {
		logic [OUT_LEN_W-1:0] longest;
		logic [OUT_LEN_W-1:0] run_length;
		logic                 duplicate;
	} res_t;

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_RD_LEFT,
		ST_RD_RIGHT,
		ST_WR_MID,
		ST_WR_LO,
		ST_WR_HI,
		ST_DONE
	} state_t;

	// Wrap the input value onto the table range
	function automatic logic [VALUE_BITS-1:0] wrap_value(input logic [IN_VALUE_W-1:0] v);
		logic [IN_VALUE_W+VALUE_BITS-1:0] wide;
		wide = {{VALUE_BITS{1'b0}}, v};
		return wide[VALUE_BITS-1:0];
	endfunction

	// Fit an internal length onto the output field width
	function automatic logic [OUT_LEN_W-1:0] to_out_len(input logic [LEN_W-1:0] len);
		logic [LEN_W+OUT_LEN_W-1:0] wide;
		wide = {{OUT_LEN_W{1'b0}}, len};
		return wide[OUT_LEN_W-1:0];
	endfunction

endpackage

`default_nettype wire

### src/lrbm_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Stands alone; no package needed.
`timescale 1ns / 1ps
`default_nettype none

module lrbm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rd_data_q
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_data_q <= mem[raddr];
	end

endmodule

`default_nettype wire

### src/lrbm_ctrl.sv
// Sequencer and merge datapath: reads the value and its neighbours from the
// table, writes the merged length back and tracks the longest run. Uses lrbm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lrbm_ctrl import lrbm_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic                   cmd,
	input  wire logic [IN_VALUE_W-1:0]  value,
	output logic                        mem_we,
	output logic      [VALUE_BITS-1:0]  mem_waddr,
	output logic      [ENTRY_W-1:0]     mem_wdata,
	output logic      [VALUE_BITS-1:0]  mem_raddr,
	input  wire logic [ENTRY_W-1:0]     mem_rdata,
	output logic                        res_valid,
	output res_t                        res,
	input  wire logic                   out_free
);

	state_t state_q, state_d;

	logic [VALUE_BITS-1:0] v_q;
	logic                  cmd_q;
	logic                  dup_q;
	logic [LEN_W-1:0]      left_q;
	logic [LEN_W-1:0]      run_q;
	logic [VALUE_BITS-1:0] lo_q;
	logic [VALUE_BITS-1:0] hi_q;
	logic [EPOCH_W-1:0]    epoch_q;
	logic [VALUE_BITS-1:0] sweep_q;
	logic [LEN_W-1:0]      longest_q;

	entry_t                rd_entry;
	entry_t                wr_entry;
	logic                  hit;
	logic [LEN_W-1:0]      v_ext;
	logic [LEN_W-1:0]      left_c;
	logic [LEN_W-1:0]      right_c;
	logic [LEN_W-1:0]      run_c;
	logic [LEN_W-1:0]      lo_c;
	logic [LEN_W-1:0]      hi_c;
	logic [LEN_W-1:0]      room_c;
	logic [LEN_W-1:0]      longest_d;
	logic                  accept;
	logic                  finish;

	assign rd_entry = entry_t'(mem_rdata);
	assign hit      = (rd_entry.tag == epoch_q);
	assign v_ext    = {1'b0, v_q};

	// Neighbours beyond either end of the range count as absent
	assign left_c  = (v_q != '0 && hit) ? rd_entry.len : '0;
	assign right_c = (v_q != VALUE_MAX && hit) ? rd_entry.len : '0;
	assign run_c   = left_q + right_c + LEN_W'(1);
	assign lo_c    = (left_c <= v_ext) ? (v_ext - left_c) : '0;
	assign room_c  = {1'b0, VALUE_MAX} - v_ext;
	assign hi_c    = (right_c <= room_c) ? (v_ext + right_c) : {1'b0, VALUE_MAX};

	assign longest_d = (cmd_q == CMD_CLEAR) ? '0 :
		((run_q > longest_q) ? run_q : longest_q);

	assign accept = (state_q == ST_IDLE) && in_valid;
	assign finish = (state_q == ST_DONE) && out_free;

	assign res.longest    = to_out_len(longest_d);
	assign res.run_length = to_out_len(run_q);
	assign res.duplicate  = dup_q;
	assign mem_wdata      = wr_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		in_stall       = 1'b1;
		mem_raddr      = v_q;
		mem_we         = 1'b0;
		mem_waddr      = v_q;
		wr_entry.tag   = epoch_q;
		wr_entry.len   = run_q;
		res_valid      = 1'b0;
		case (state_q)
			ST_SWEEP: begin
				mem_we       = 1'b1;
				mem_waddr    = sweep_q;
				wr_entry.tag = EPOCH_SWEPT;
				wr_entry.len = '0;
				if (sweep_q == VALUE_MAX) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall  = 1'b0;
				mem_raddr = wrap_value(value);
				if (in_valid) begin
					state_d = (cmd == CMD_CLEAR) ? ST_DONE : ST_RD_LEFT;
				end
			end
			ST_RD_LEFT: begin
				// entry at the value itself arrives now
				mem_raddr = v_q - VALUE_BITS'(1);
				state_d   = hit ? ST_DONE : ST_RD_RIGHT;
			end
			ST_RD_RIGHT: begin
				mem_raddr = v_q + VALUE_BITS'(1);
				state_d   = ST_WR_MID;
			end
			ST_WR_MID: begin
				mem_we       = 1'b1;
				wr_entry.len = left_q + right_c + LEN_W'(1);
				state_d      = ST_WR_LO;
			end
			ST_WR_LO: begin
				mem_we    = 1'b1;
				mem_waddr = lo_q;
				state_d   = ST_WR_HI;
			end
			ST_WR_HI: begin
				mem_we    = 1'b1;
				mem_waddr = hi_q;
				state_d   = ST_DONE;
			end
			ST_DONE: begin
				res_valid = 1'b1;
				if (out_free) begin
					state_d = (cmd_q == CMD_CLEAR && epoch_q == EPOCH_MAX) ?
						ST_SWEEP : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q   <= EPOCH_FIRST;
			sweep_q   <= '0;
			longest_q <= '0;
		end else begin
			if (state_q == ST_SWEEP) begin
				sweep_q <= sweep_q + VALUE_BITS'(1);
			end
			if (finish) begin
				longest_q <= longest_d;
				if (cmd_q == CMD_CLEAR) begin
					// retire the epoch; a full sweep resets the tags on wrap
					epoch_q <= (epoch_q == EPOCH_MAX) ? EPOCH_FIRST :
						epoch_q + EPOCH_W'(1);
				end
			end
		end
	end

	// Item payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			v_q    <= wrap_value(value);
			cmd_q  <= cmd;
			dup_q  <= 1'b0;
			run_q  <= '0;
			left_q <= '0;
		end
		if (state_q == ST_RD_LEFT) begin
			dup_q <= hit;
		end
		if (state_q == ST_RD_RIGHT) begin
			left_q <= left_c;
			lo_q   <= lo_c[VALUE_BITS-1:0];
		end
		if (state_q == ST_WR_MID) begin
			run_q <= run_c;
			hi_q  <= hi_c[VALUE_BITS-1:0];
		end
	end

endmodule

`default_nettype wire

### src/lrbm_obuf.sv
// Output register: holds one result until the consumer takes it, so the
// controller can move on. Uses lrbm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lrbm_obuf import lrbm_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  res_valid,
	input  wire res_t                  res,
	output logic                       out_free,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic      [OUT_LEN_W-1:0]  longest,
	output logic      [OUT_LEN_W-1:0]  run_length,
	output logic                       duplicate
);

	logic valid_q;
	res_t res_q;

	assign out_free   = !valid_q || !out_stall;
	assign out_valid  = valid_q;
	assign longest    = res_q.longest;
	assign run_length = res_q.run_length;
	assign duplicate  = res_q.duplicate;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res_valid) begin
			res_q <= res;
		end
	end

endmodule

`default_nettype wire

### src/longest_run_by_boundary_merge_unit.sv
// Longest consecutive run unit: one presence mark and run length per value in a
// single table RAM, one read and one write port with a registered read. After
// reset, and again after every 255th clear, all 2^VALUE_BITS entries (1024 here)
// are swept with the input stalled. A fresh insert makes three reads, of the
// value and both neighbours, then three writes of the merged length at the
// value and both run ends through the one RAM, before the next item is taken;
// a duplicate stops after the first read and a clear skips the table. Results
// sit in an output register, so a stalled consumer only holds up the block once
// a second result is ready. Uses lrbm_pkg, lrbm_ram, lrbm_ctrl and lrbm_obuf.
`timescale 1ns / 1ps
`default_nettype none

module longest_run_by_boundary_merge_unit import lrbm_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic                  cmd,
	input  wire logic [IN_VALUE_W-1:0] value,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic      [OUT_LEN_W-1:0]  longest,
	output logic      [OUT_LEN_W-1:0]  run_length,
	output logic                       duplicate
);

	logic                  mem_we;
	logic [VALUE_BITS-1:0] mem_waddr;
	logic [ENTRY_W-1:0]    mem_wdata;
	logic [VALUE_BITS-1:0] mem_raddr;
	logic [ENTRY_W-1:0]    mem_rdata;
	logic                  res_valid;
	res_t                  res;
	logic                  out_free;

	lrbm_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk       (clk),
		.we        (mem_we),
		.waddr     (mem_waddr),
		.wdata     (mem_wdata),
		.raddr     (mem_raddr),
		.rd_data_q (mem_rdata)
	);

	lrbm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.value     (value),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.res_valid (res_valid),
		.res       (res),
		.out_free  (out_free)
	);

	lrbm_obuf u_obuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.res_valid  (res_valid),
		.res        (res),
		.out_free   (out_free),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.longest    (longest),
		.run_length (run_length),
		.duplicate  (duplicate)
	);

endmodule

`default_nettype wire

### src/lrbm_checker.sv
// Port-level checks on the result channel of the longest-run unit, bound to
// the top level. Uses lrbm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lrbm_checker import lrbm_pkg::*; (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 out_valid,
	input wire logic                 out_stall,
	input wire logic [OUT_LEN_W-1:0] longest,
	input wire logic [OUT_LEN_W-1:0] run_length,
	input wire logic                 duplicate
);

	// A stalled transaction stays offered
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result withdrawn while stalled");

	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(longest) && $stable(run_length)
			&& $stable(duplicate))
		else $error("result payload changed while stalled");

	a_dup_no_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && duplicate |-> run_length == '0)
		else $error("duplicate reported with a run length");

	a_run_le_longest: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> run_length <= longest)
		else $error("run longer than the longest run");

	a_longest_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(longest) <= 32'(TABLE_DEPTH))
		else $error("longest run exceeds the table range");

endmodule

bind longest_run_by_boundary_merge_unit lrbm_checker u_lrbm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.longest    (longest),
	.run_length (run_length),
	.duplicate  (duplicate)
);

`default_nettype wire
